// ===== rtl/core/rk4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the RK4 step core: micro-op codes, register file slots,
// reset values and the fixed micro-program. No dependencies.
package rk4_pkg;

  localparam int DEF_FRAC_BITS   = 32;
  localparam int DEF_VALUE_WIDTH = 48;
  localparam int WORD_W          = 64;

  localparam logic [32:0] RST_STEP_SIZE  = 33'd429497;
  localparam logic [47:0] RST_START_X    = 48'd1288490189;
  localparam logic [47:0] RST_START_Y    = 48'd34359738368;
  localparam logic [31:0] RST_STEP_LIMIT = 32'd100000;

  // Configuration register indexes (byte address / 8).
  localparam logic [1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_START_X    = 2'd1;
  localparam logic [1:0] CFG_START_Y    = 2'd2;
  localparam logic [1:0] CFG_STEP_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    OP_LD    = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_HALF  = 3'd4,
    OP_SIXTH = 3'd5
  } op_t;

  typedef logic [3:0] reg_idx_t;

  localparam reg_idx_t R_X0  = 4'd0;
  localparam reg_idx_t R_Y0  = 4'd1;
  localparam reg_idx_t R_H   = 4'd2;
  localparam reg_idx_t R_C12 = 4'd3;
  localparam reg_idx_t R_XS  = 4'd4;
  localparam reg_idx_t R_YS  = 4'd5;
  localparam reg_idx_t R_Y2  = 4'd6;
  localparam reg_idx_t R_Y3  = 4'd7;
  localparam reg_idx_t R_X2  = 4'd8;
  localparam reg_idx_t R_T   = 4'd9;
  localparam reg_idx_t R_U   = 4'd10;
  localparam reg_idx_t R_SK  = 4'd11;
  localparam reg_idx_t R_SL  = 4'd12;
  localparam reg_idx_t R_K   = 4'd13;
  localparam reg_idx_t R_L   = 4'd14;
  localparam int       RF_DEPTH = 15;

  // Load sources, carried in the first operand field of a load.
  localparam reg_idx_t SRC_CURX = 4'd0;
  localparam reg_idx_t SRC_CURY = 4'd1;
  localparam reg_idx_t SRC_H    = 4'd2;
  localparam reg_idx_t SRC_C12  = 4'd3;

  localparam int PROG_LEN = 84;
  localparam int PC_W     = 7;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t      op;
    reg_idx_t dst;
    reg_idx_t sa;
    reg_idx_t sb;
  } instr_t;

  function automatic instr_t mk(op_t op, reg_idx_t d, reg_idx_t a, reg_idx_t b);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.sa  = a;
    i.sb  = b;
    return i;
  endfunction

  // Both derivatives at (x, y); dy/dt lands in kd and dx/dt in ld.
  function automatic instr_t eval_instr(int j, reg_idx_t x, reg_idx_t y,
                                        reg_idx_t kd, reg_idx_t ld);
    instr_t i;
    case (j)
      0:  i = mk(OP_MUL, R_Y2, y, y);
      1:  i = mk(OP_MUL, R_Y3, R_Y2, y);
      2:  i = mk(OP_MUL, R_X2, x, x);
      3:  i = mk(OP_MUL, R_T, R_C12, R_Y3);
      4:  i = mk(OP_MUL, R_T, R_T, R_X2);
      5:  i = mk(OP_SUB, ld, R_T, x);
      6:  i = mk(OP_MUL, R_U, R_Y3, R_Y2);
      7:  i = mk(OP_MUL, R_Y2, R_X2, R_X2);
      8:  i = mk(OP_MUL, R_T, R_U, R_Y2);
      9:  i = mk(OP_ADD, R_U, R_T, R_T);
      10: i = mk(OP_ADD, R_U, R_U, R_T);
      default: i = mk(OP_SUB, kd, y, R_U);
    endcase
    return i;
  endfunction

  // Trial point from the slopes in kd and ld, with or without halving.
  function automatic instr_t upd_instr(int j, reg_idx_t kd, reg_idx_t ld, logic halve);
    instr_t i;
    if (halve) begin
      case (j)
        0: i = mk(OP_MUL, R_T, ld, R_H);
        1: i = mk(OP_HALF, R_T, R_T, R_T);
        2: i = mk(OP_ADD, R_XS, R_X0, R_T);
        3: i = mk(OP_MUL, R_T, kd, R_H);
        4: i = mk(OP_HALF, R_T, R_T, R_T);
        default: i = mk(OP_ADD, R_YS, R_Y0, R_T);
      endcase
    end else begin
      case (j)
        0: i = mk(OP_MUL, R_T, ld, R_H);
        1: i = mk(OP_ADD, R_XS, R_X0, R_T);
        2: i = mk(OP_MUL, R_T, kd, R_H);
        default: i = mk(OP_ADD, R_YS, R_Y0, R_T);
      endcase
    end
    return i;
  endfunction

  // Adds twice the current slopes into the running sums.
  function automatic instr_t acc_instr(int j);
    instr_t i;
    case (j)
      0: i = mk(OP_ADD, R_T, R_K, R_K);
      1: i = mk(OP_ADD, R_SK, R_SK, R_T);
      2: i = mk(OP_ADD, R_T, R_L, R_L);
      default: i = mk(OP_ADD, R_SL, R_SL, R_T);
    endcase
    return i;
  endfunction

  function automatic instr_t prog_instr(pc_t pc);
    int     p;
    instr_t i;
    p = int'(pc);
    if (p < 4) begin
      case (p)
        0: i = mk(OP_LD, R_X0, SRC_CURX, SRC_CURX);
        1: i = mk(OP_LD, R_Y0, SRC_CURY, SRC_CURY);
        2: i = mk(OP_LD, R_H, SRC_H, SRC_H);
        default: i = mk(OP_LD, R_C12, SRC_C12, SRC_C12);
      endcase
    end else if (p < 16) begin
      i = eval_instr(p - 4, R_X0, R_Y0, R_SK, R_SL);
    end else if (p < 22) begin
      i = upd_instr(p - 16, R_SK, R_SL, 1'b1);
    end else if (p < 34) begin
      i = eval_instr(p - 22, R_XS, R_YS, R_K, R_L);
    end else if (p < 40) begin
      i = upd_instr(p - 34, R_K, R_L, 1'b1);
    end else if (p < 44) begin
      i = acc_instr(p - 40);
    end else if (p < 56) begin
      i = eval_instr(p - 44, R_XS, R_YS, R_K, R_L);
    end else if (p < 60) begin
      i = upd_instr(p - 56, R_K, R_L, 1'b0);
    end else if (p < 64) begin
      i = acc_instr(p - 60);
    end else if (p < 76) begin
      i = eval_instr(p - 64, R_XS, R_YS, R_K, R_L);
    end else if (p < 78) begin
      i = (p == 76) ? mk(OP_ADD, R_SK, R_SK, R_K) : mk(OP_ADD, R_SL, R_SL, R_L);
    end else begin
      case (p)
        78: i = mk(OP_MUL, R_T, R_H, R_SK);
        79: i = mk(OP_SIXTH, R_T, R_T, R_T);
        80: i = mk(OP_ADD, R_Y0, R_Y0, R_T);
        81: i = mk(OP_MUL, R_T, R_H, R_SL);
        82: i = mk(OP_SIXTH, R_T, R_T, R_T);
        default: i = mk(OP_ADD, R_X0, R_X0, R_T);
      endcase
    end
    return i;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rk4_coupled_ode_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// RK4 step core for dx/dt = 1.2*y^3*x^2 - x, dy/dt = y - 3*y^5*x^4; depends on rk4_pkg.
// A restart word gives its result in the cycle after acceptance. A step word runs an
// 84-entry micro-program on one shared 32x32 multiplier: 40 multiplies and two divides
// by six (reciprocal multiply), plus 42 short ops. One word at a time; rst_n (synchronous)
// loads the default registers and point.
module rk4_coupled_ode_step_core
  import rk4_pkg::*;
#(
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      out_x_value,
  output logic [47:0]      out_y_value,
  output logic [31:0]      out_step_index,
  output logic             out_last_step,
  output logic             out_overflow,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [63:0]  VMAX_U = {1'b0, {63{1'b1}}} >> (WORD_W - VALUE_WIDTH);
  localparam logic [63:0]  VMIN_U = ~VMAX_U;
  localparam logic [63:0]  C12    = ((64'd12 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [127:0] RND    = 128'd1 << (FRAC_BITS - 1);
  // Reciprocal of three scaled by 2^65; exact for every 64-bit dividend.
  localparam logic [63:0]  RECIP3   = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam int           RECIP_SH = 65;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_MRND  = 7'b0010000,
    S_MWR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // {saturated, value}: signed magnitude fitted into the value range.
  function automatic logic [64:0] fit_mag(logic neg, logic [127:0] m);
    logic [127:0] lim;
    logic         sat;
    logic [63:0]  v;
    lim = neg ? ({64'd0, VMAX_U} + 128'd1) : {64'd0, VMAX_U};
    sat = m > lim;
    if (sat) begin
      v = neg ? VMIN_U : VMAX_U;
    end else begin
      v = neg ? (64'd0 - m[63:0]) : m[63:0];
    end
    return {sat, v};
  endfunction

  function automatic logic [64:0] fit_sum(logic [64:0] s);
    logic [64:0] v;
    logic        sat;
    sat = 1'b0;
    v   = s;
    if ($signed(s) > $signed({1'b0, VMAX_U})) begin
      sat = 1'b1;
      v   = {1'b0, VMAX_U};
    end else if ($signed(s) < $signed({1'b1, VMIN_U})) begin
      sat = 1'b1;
      v   = {1'b1, VMIN_U};
    end
    return {sat, v[63:0]};
  endfunction

  function automatic logic [63:0] mag_of(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [64:0] load48(logic [47:0] v);
    return fit_sum({{17{v[47]}}, v});
  endfunction

  localparam logic [64:0] LD_RST_X = load48(RST_START_X);
  localparam logic [64:0] LD_RST_Y = load48(RST_START_Y);

  state_t       state_r, state_nxt;
  pc_t          pc_r, pc_nxt;
  instr_t       ins;
  logic [32:0]  step_size_r;
  logic [47:0]  start_x_r, start_y_r;
  logic [31:0]  step_limit_r;
  logic [63:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [31:0]  step_cnt_r, step_cnt_nxt;
  logic         last_r, last_nxt, ovf_r, ovf_nxt;
  logic [63:0]  opa_r, opb_r;
  logic [63:0]  ma_r, ma_nxt, mb_r, mb_nxt;
  logic         neg_r, neg_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [1:0]   pp_sh_r, pp_sh_nxt;
  logic [2:0]   mcnt_r, mcnt_nxt;
  logic [127:0] prod_r, prod_nxt, rq_r, rq_nxt;
  logic         wr_en;
  logic [63:0]  wr_data;
  logic [63:0]  rf [RF_DEPTH];

  logic [64:0]  res;
  logic [31:0]  a_sel, b_sel;
  logic [127:0] pp_shifted;
  logic [64:0]  six_sum;
  logic [64:0]  ld_x, ld_y;
  logic         cfg_wr;

  assign ins      = prog_instr(pc_r);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_x_value    = cur_x_r[47:0];
  assign out_y_value    = cur_y_r[47:0];
  assign out_step_index = step_cnt_r;
  assign out_last_step  = last_r;
  assign out_overflow   = ovf_r;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign six_sum = {1'b0, mag_of(opa_r)} + 65'd3;
  assign ld_x    = load48(start_x_r);
  assign ld_y    = load48(start_y_r);

  always_comb begin
    case (paddr[4:3])
      CFG_STEP_SIZE:  prdata = {31'd0, step_size_r};
      CFG_START_X:    prdata = {16'd0, start_x_r};
      CFG_START_Y:    prdata = {16'd0, start_y_r};
      CFG_STEP_LIMIT: prdata = {32'd0, step_limit_r};
      default:        prdata = 64'd0;
    endcase
  end

  always_comb begin
    case (mcnt_r[1:0])
      2'd0:    begin a_sel = ma_r[31:0];  b_sel = mb_r[31:0];  end
      2'd1:    begin a_sel = ma_r[31:0];  b_sel = mb_r[63:32]; end
      2'd2:    begin a_sel = ma_r[63:32]; b_sel = mb_r[31:0];  end
      default: begin a_sel = ma_r[63:32]; b_sel = mb_r[63:32]; end
    endcase
    case (pp_sh_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd3:    pp_shifted = {pp_r, 64'd0};
      default: pp_shifted = {32'd0, pp_r, 32'd0};
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    step_cnt_nxt = step_cnt_r;
    last_nxt     = last_r;
    ovf_nxt      = ovf_r;
    ma_nxt       = ma_r;
    mb_nxt       = mb_r;
    neg_nxt      = neg_r;
    pp_nxt       = pp_r;
    pp_sh_nxt    = pp_sh_r;
    mcnt_nxt     = mcnt_r;
    prod_nxt     = prod_r;
    rq_nxt       = rq_r;
    wr_en        = 1'b0;
    wr_data      = 64'd0;
    res          = 65'd0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            cur_x_nxt    = ld_x[63:0];
            cur_y_nxt    = ld_y[63:0];
            ovf_nxt      = ld_x[64] | ld_y[64];
            step_cnt_nxt = 32'd0;
            last_nxt     = (step_limit_r == 32'd0);
            state_nxt    = S_OUT;
          end else begin
            pc_nxt    = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC: begin
        case (ins.op)
          OP_MUL: begin
            ma_nxt    = mag_of(opa_r);
            mb_nxt    = mag_of(opb_r);
            neg_nxt   = opa_r[63] ^ opb_r[63];
            prod_nxt  = '0;
            mcnt_nxt  = 3'd0;
            state_nxt = S_MUL;
          end
          OP_SIXTH: begin
            // Rounded sixth: halve the biased magnitude, then divide by three.
            ma_nxt    = six_sum[64:1];
            mb_nxt    = RECIP3;
            neg_nxt   = opa_r[63];
            prod_nxt  = '0;
            mcnt_nxt  = 3'd0;
            state_nxt = S_MUL;
          end
          OP_ADD:  res = fit_sum({opa_r[63], opa_r} + {opb_r[63], opb_r});
          OP_SUB:  res = fit_sum({opa_r[63], opa_r} - {opb_r[63], opb_r});
          OP_HALF: res = fit_mag(opa_r[63], {63'd0, ({1'b0, mag_of(opa_r)} + 65'd1)} >> 1);
          OP_LD: begin
            case (ins.sa)
              SRC_CURX: res = {1'b0, cur_x_r};
              SRC_CURY: res = {1'b0, cur_y_r};
              SRC_H:    res = {1'b0, 31'd0, step_size_r};
              default:  res = {1'b0, C12};
            endcase
          end
          default: res = 65'd0;
        endcase
        if (ins.op != OP_MUL && ins.op != OP_SIXTH) begin
          wr_en = 1'b1;
        end
      end
      S_MUL: begin
        if (mcnt_r != 3'd4) begin
          pp_nxt    = 64'(a_sel) * 64'(b_sel);
          pp_sh_nxt = mcnt_r[1:0];
        end
        if (mcnt_r != 3'd0) begin
          prod_nxt = prod_r + pp_shifted;
        end
        mcnt_nxt = mcnt_r + 3'd1;
        if (mcnt_r == 3'd4) begin
          state_nxt = S_MRND;
        end
      end
      S_MRND: begin
        if (ins.op == OP_SIXTH) begin
          rq_nxt = prod_r >> RECIP_SH;
        end else begin
          rq_nxt = (prod_r + RND) >> FRAC_BITS;
        end
        state_nxt = S_MWR;
      end
      S_MWR: begin
        res   = fit_mag(neg_r, rq_r);
        wr_en = 1'b1;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (wr_en) begin
      wr_data = res[63:0];
      ovf_nxt = ovf_nxt | res[64];
      if (ins.dst == R_X0) begin
        cur_x_nxt = res[63:0];
      end
      if (ins.dst == R_Y0) begin
        cur_y_nxt = res[63:0];
      end
      if (pc_r == pc_t'(PROG_LEN - 1)) begin
        if (step_cnt_r != 32'hFFFF_FFFF) begin
          step_cnt_nxt = step_cnt_r + 32'd1;
        end
        last_nxt  = (step_cnt_nxt >= step_limit_r);
        state_nxt = S_OUT;
      end else begin
        pc_nxt    = pc_r + pc_t'(1);
        state_nxt = S_FETCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      step_size_r  <= RST_STEP_SIZE;
      start_x_r    <= RST_START_X;
      start_y_r    <= RST_START_Y;
      step_limit_r <= RST_STEP_LIMIT;
      cur_x_r      <= LD_RST_X[63:0];
      cur_y_r      <= LD_RST_Y[63:0];
      step_cnt_r   <= 32'd0;
      last_r       <= 1'b0;
      ovf_r        <= 1'b0;
      mcnt_r       <= 3'd0;
    end else begin
      state_r    <= state_nxt;
      pc_r       <= pc_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      step_cnt_r <= step_cnt_nxt;
      last_r     <= last_nxt;
      ovf_r      <= ovf_nxt;
      mcnt_r     <= mcnt_nxt;
      if (cfg_wr) begin
        case (paddr[4:3])
          CFG_STEP_SIZE:  step_size_r  <= pwdata[32:0];
          CFG_START_X:    start_x_r    <= pwdata[47:0];
          CFG_START_Y:    start_y_r    <= pwdata[47:0];
          CFG_STEP_LIMIT: step_limit_r <= pwdata[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    neg_r   <= neg_nxt;
    pp_r    <= pp_nxt;
    pp_sh_r <= pp_sh_nxt;
    prod_r  <= prod_nxt;
    rq_r    <= rq_nxt;
  end

  // Working register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf[ins.dst] <= wr_data;
    end
    if (state_r == S_FETCH) begin
      opa_r <= rf[ins.sa];
      opb_r <= rf[ins.sb];
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output handshakes open together");

  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_restart) |=> (out_valid && out_step_index == 32'd0))
    else $error("restart word did not give a zero-count result");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pc_r) < PROG_LEN)
    else $error("program counter beyond the micro-program");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_restart && out_step_index != 32'hFFFF_FFFF)
    |=> $stable(out_step_index))
    else $error("step count changed before the step finished");

endmodule
`default_nettype wire
